>>> design/rci_pkg.sv
// Shared types and constants for the raster costmap inflation block.
`timescale 1ns / 1ps

package rci_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_SIZE_W = 10;
    localparam int VALUE_W    = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH    = 3'd0,
        CFG_MAP_HEIGHT   = 3'd1,
        CFG_LETHAL_VALUE = 3'd2,
        CFG_CENTER_COST  = 3'd3,
        CFG_EDGE_COST    = 3'd4,
        CFG_CORNER_COST  = 3'd5
    } t_cfg_idx;

    // Input function codes
    localparam logic FUNC_CELL  = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // Reset values
    localparam int             SIZE_RST        = 512;
    localparam logic [VALUE_W-1:0] LETHAL_RST      = 8'd254;
    localparam logic [VALUE_W-1:0] CENTER_RST      = 8'd254;
    localparam logic [VALUE_W-1:0] EDGE_RST        = 8'd80;
    localparam logic [VALUE_W-1:0] CORNER_RST      = 8'd50;

    // Window layout: column k at bits 3k..3k+2, top row at the low bit
    localparam logic [8:0] WIN_LEFT_COL  = 9'h007;
    localparam logic [8:0] WIN_RIGHT_COL = 9'h1C0;
    localparam logic [8:0] WIN_TOP_ROW   = 9'h049;
    localparam logic [8:0] WIN_BOT_ROW   = 9'h124;
    localparam logic [8:0] WIN_CENTER    = 9'h010;
    localparam logic [8:0] WIN_EDGES     = 9'h0AA;
    localparam logic [8:0] WIN_CORNERS   = 9'h145;

    typedef struct packed {
        logic [VALUE_W-1:0] cost;
        logic               last;
    } t_result;

endpackage

>>> design/raster_costmap_inflation.sv
// Top level: 3x3 costmap inflation over a raster-ordered occupancy map.
`timescale 1ns / 1ps

//  channel | direction | handshake                  | beat contents
//  --------+-----------+----------------------------+---------------------------
//  in      | to block  | i_in_valid / o_in_ready    | i_func, i_cell_req
//  out     | from block| o_out_valid / i_out_ready  | o_cost, o_last
//  cfg     | to block  | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
//  One input beat per clock unless stalled. A result is registered in the cycle
//  after the beat that produces it; in beats it lags one map row plus one cell,
//  and flush beats after the last cell drain the rest. Synchronous reset clears
//  the counters, the window, the handshake state and the configuration; the
//  line stores are not cleared (their stale bits only reach masked positions).
//  o_in_ready drops only while the skid register holds a stalled result.

module raster_costmap_inflation
    import rci_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_func,
    input  logic [VALUE_W-1:0]    i_cell_req,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [VALUE_W-1:0]    o_cost,
    output logic                  o_last,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // column / row counter widths; size compares are done in wider words
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int WSW = (CW + 1 > CFG_SIZE_W) ? CW + 1 : CFG_SIZE_W;
    localparam int HSW = (RW > CFG_SIZE_W) ? RW : CFG_SIZE_W;
    localparam int WID_RST = (SIZE_RST > MAX_WIDTH) ? MAX_WIDTH : SIZE_RST;
    localparam int HGT_RST = (SIZE_RST > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RST;

    // ---------------- configuration (sizes kept clamped, minus one) ----------
    logic [WSW-1:0]     r_wid_m1, n_wid_m1;
    logic [HSW-1:0]     r_hgt_m1, n_hgt_m1;
    logic [VALUE_W-1:0] r_lethal, r_center, r_edge, r_corner;
    logic [WSW-1:0]     cfg_w_ext;
    logic [HSW-1:0]     cfg_h_ext;

    always_comb begin
        cfg_w_ext = WSW'(i_cfg_data[CFG_SIZE_W-1:0]);
        cfg_h_ext = HSW'(i_cfg_data[CFG_SIZE_W-1:0]);
        if (cfg_w_ext == '0) begin
            n_wid_m1 = '0;
        end else if (cfg_w_ext > WSW'(MAX_WIDTH)) begin
            n_wid_m1 = WSW'(MAX_WIDTH - 1);
        end else begin
            n_wid_m1 = cfg_w_ext - WSW'(1);
        end
        if (cfg_h_ext == '0) begin
            n_hgt_m1 = '0;
        end else if (cfg_h_ext > HSW'(MAX_HEIGHT)) begin
            n_hgt_m1 = HSW'(MAX_HEIGHT - 1);
        end else begin
            n_hgt_m1 = cfg_h_ext - HSW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wid_m1 <= WSW'(WID_RST - 1);
            r_hgt_m1 <= HSW'(HGT_RST - 1);
            r_lethal <= LETHAL_RST;
            r_center <= CENTER_RST;
            r_edge   <= EDGE_RST;
            r_corner <= CORNER_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MAP_WIDTH:    r_wid_m1 <= n_wid_m1;
                CFG_MAP_HEIGHT:   r_hgt_m1 <= n_hgt_m1;
                CFG_LETHAL_VALUE: r_lethal <= i_cfg_data[VALUE_W-1:0];
                CFG_CENTER_COST:  r_center <= i_cfg_data[VALUE_W-1:0];
                CFG_EDGE_COST:    r_edge   <= i_cfg_data[VALUE_W-1:0];
                CFG_CORNER_COST:  r_corner <= i_cfg_data[VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- position counters and window ---------------------------
    logic [CW-1:0] r_in_col, n_in_col;
    logic [RW-1:0] r_in_row, n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;
    logic [8:0]    r_win, n_win;

    // line store word: bit 1 = row above, bit 0 = two rows above
    logic [1:0]    ram_q, line_q, line_d;
    logic [CW-1:0] ram_raddr;
    logic          r_byp_valid, n_byp_valid;
    logic [1:0]    r_byp_data;

    logic          accept, in_map, step, mark, top, mid, emit, col_wrap;
    logic [8:0]    win_new, view, masked;
    logic          ocol_first, ocol_last, orow_first, orow_last;
    t_result       res;

    assign accept = i_in_valid & o_in_ready;
    assign in_map = HSW'(r_in_row) <= r_hgt_m1;
    // a flush beat while cells are still due is dropped without effect
    assign step   = accept & ~(in_map & (i_func == FUNC_FLUSH));
    // past the last row every beat (cell or flush) is a drain beat
    assign mark   = in_map & (i_cell_req == r_lethal);

    // forward the word written last cycle when the read hit the same column
    assign line_q = r_byp_valid ? r_byp_data : ram_q;
    assign top    = line_q[0];
    assign mid    = line_q[1];
    assign line_d = {mark, mid};

    assign win_new  = {mark, mid, top, r_win[8:3]};
    assign emit     = (r_in_row >= RW'(2)) || ((r_in_row == RW'(1)) && (r_in_col != '0));
    // at column 0 the newest column belongs to the next row, so it is left out
    assign view     = (r_in_col == '0) ? {3'b000, r_win[8:3]} : win_new;
    assign col_wrap = WSW'(r_in_col) >= r_wid_m1;

    // border masking and cost pick
    always_comb begin
        ocol_first = r_out_col == '0;
        ocol_last  = WSW'(r_out_col) >= r_wid_m1;
        orow_first = r_out_row == '0;
        orow_last  = HSW'(r_out_row) >= r_hgt_m1;
        masked = view;
        if (ocol_first) masked = masked & ~WIN_LEFT_COL;
        if (ocol_last)  masked = masked & ~WIN_RIGHT_COL;
        if (orow_first) masked = masked & ~WIN_TOP_ROW;
        if (orow_last)  masked = masked & ~WIN_BOT_ROW;
        res.cost = '0;
        if ((masked & WIN_CENTER) != '0)  res.cost = r_center;
        if (((masked & WIN_EDGES) != '0) && (r_edge > res.cost)) begin
            res.cost = r_edge;
        end
        if (((masked & WIN_CORNERS) != '0) && (r_corner > res.cost)) begin
            res.cost = r_corner;
        end
        res.last = orow_last & ocol_last;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_win     = r_win;
        if (step) begin
            n_win = win_new;
            if (col_wrap) begin
                n_in_col = '0;
                n_in_row = r_in_row + RW'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
            if (emit) begin
                if (ocol_last) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + RW'(1);
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
                // end of map: start over for the next one
                if (res.last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                    n_win     = '0;
                end
            end
        end
    end

    // read ahead at the column the next beat will use
    assign ram_raddr   = i_rst_n ? n_in_col : '0;
    assign n_byp_valid = step & (ram_raddr == r_in_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_win       <= '0;
            r_byp_valid <= 1'b0;
        end else begin
            r_in_col    <= n_in_col;
            r_in_row    <= n_in_row;
            r_out_col   <= n_out_col;
            r_out_row   <= n_out_row;
            r_win       <= n_win;
            r_byp_valid <= n_byp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= line_d;
    end

    rci_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (step),
        .i_waddr (r_in_col),
        .i_wdata (line_d),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // ---------------- output register with skid ------------------------------
    logic    r_out_valid, r_skd_valid;
    t_result r_out, r_skd;
    logic    push, pop;

    assign push = step & emit;
    assign pop  = r_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (pop) begin
                r_skd_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_out_valid && !pop) begin
                r_skd_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (pop) begin
                r_out <= r_skd;
            end
        end else if (push) begin
            if (r_out_valid && !pop) begin
                r_skd <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_in_ready  = ~r_skd_valid;
    assign o_out_valid = r_out_valid;
    assign o_cost      = r_out.cost;
    assign o_last      = r_out.last;

endmodule

>>> design/rci_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rci_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
